>>> rtl/core/bmp24_to_rgba_stream_decoder_core_assert.svh
// assertion macros shared by the decoder core
`ifndef BMP24_TO_RGBA_STREAM_DECODER_CORE_ASSERT_SVH
`define BMP24_TO_RGBA_STREAM_DECODER_CORE_ASSERT_SVH

// checked only outside reset
`define BMP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define BMP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/core/bmp24_pkg.sv
package bmp24_pkg;

  // default largest accepted width or height
  localparam int MaxDimDefault = 4096;

  // header layout
  localparam logic [5:0] WidthOff  = 6'h12;
  localparam logic [5:0] HeightOff = 6'h16;
  localparam logic [5:0] LastHdr   = 6'd53;
  localparam logic [7:0] SigB      = 8'h42;
  localparam logic [7:0] SigM      = 8'h4d;

  // color key threshold and opaque value
  localparam logic [7:0] KeyLimit  = 8'd5;
  localparam logic [7:0] Opaque    = 8'hff;

  // decoupling queue depth
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);

  typedef enum logic [1:0] {
    PhIdle,
    PhHeader,
    PhPixels,
    PhDone
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       header_error;
    logic       final_pixel;
  } out_item_t;

  // classified work from front to back
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       header_error;
    logic       final_pixel;
  } work_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

endpackage

>>> rtl/core/bmp24_front.sv
module bmp24_front import bmp24_pkg::*; #(
  parameter int MAX_DIM = MaxDimDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     acc_i,
  input  in_item_t item_i,
  output logic     push_o,
  output work_t    work_o
);

  localparam int DimW = $clog2(MAX_DIM + 1);

  phase_e           phase_q, phase_d;
  logic [5:0]       hdr_off_q, hdr_off_d;
  logic             sig_ok_q, sig_ok_d;
  logic [31:0]      width_q, width_d;
  logic [31:0]      height_q, height_d;
  logic [DimW-1:0]  img_w_q, img_w_d;
  logic [DimW-1:0]  img_h_q, img_h_d;
  logic [DimW-1:0]  col_q, col_d;
  logic [DimW-1:0]  row_q, row_d;
  logic [1:0]       bip_q, bip_d;
  logic [1:0]       pad_q, pad_d;
  logic [1:0]       row_pad_q, row_pad_d;
  logic [7:0]       blue_q, blue_d;
  logic [7:0]       green_q, green_d;

  phase_e      phase;
  logic [5:0]  off;
  logic        sig;
  logic [31:0] ww;
  logic [31:0] hw;
  logic [1:0]  lane;
  logic        bad;
  logic [7:0]  b;

  // header gathering, pixel grouping and padding skip
  always_comb begin
    phase_d   = phase_q;
    hdr_off_d = hdr_off_q;
    sig_ok_d  = sig_ok_q;
    width_d   = width_q;
    height_d  = height_q;
    img_w_d   = img_w_q;
    img_h_d   = img_h_q;
    col_d     = col_q;
    row_d     = row_q;
    bip_d     = bip_q;
    pad_d     = pad_q;
    row_pad_d = row_pad_q;
    blue_d    = blue_q;
    green_d   = green_q;
    push_o    = 1'b0;
    work_o    = '0;
    b         = item_i.data_byte;
    lane      = '0;
    bad       = 1'b0;

    phase = phase_q;
    off   = hdr_off_q;
    sig   = sig_ok_q;
    ww    = width_q;
    hw    = height_q;

    // start of a new file abandons whatever was going on
    if (acc_i && item_i.file_start) begin
      phase = PhHeader;
      off   = '0;
      sig   = 1'b1;
      ww    = '0;
      hw    = '0;
      col_d = '0;
      row_d = '0;
      bip_d = '0;
      pad_d = '0;
    end

    if (acc_i) begin
      unique case (phase)
        PhHeader: begin
          if (off == 6'd0 && b != SigB) sig = 1'b0;
          if (off == 6'd1 && b != SigM) sig = 1'b0;
          if (off >= WidthOff && off < WidthOff + 6'd4) begin
            lane = 2'(off - WidthOff);
            ww[{lane, 3'b000} +: 8] = b;
          end
          if (off >= HeightOff && off < HeightOff + 6'd4) begin
            lane = 2'(off - HeightOff);
            hw[{lane, 3'b000} +: 8] = b;
          end
          if (off < LastHdr) begin
            off = off + 6'd1;
          end else begin
            bad = !sig || ww == 32'd0 || ww > 32'(MAX_DIM) ||
                  hw == 32'd0 || hw > 32'(MAX_DIM);
            if (bad) begin
              phase               = PhDone;
              push_o              = 1'b1;
              work_o.header_error = 1'b1;
            end else begin
              phase     = PhPixels;
              img_w_d   = ww[DimW-1:0];
              img_h_d   = hw[DimW-1:0];
              // (4 - 3w mod 4) mod 4 reduces to w mod 4
              row_pad_d = ww[1:0];
              col_d     = '0;
              row_d     = '0;
              bip_d     = '0;
              pad_d     = '0;
            end
          end
        end
        PhPixels: begin
          if (pad_q != 2'd0) begin
            pad_d = pad_q - 2'd1;
          end else begin
            unique case (bip_q)
              2'd0: begin
                blue_d = b;
                bip_d  = 2'd1;
              end
              2'd1: begin
                green_d = b;
                bip_d   = 2'd2;
              end
              default: begin
                bip_d        = 2'd0;
                push_o       = 1'b1;
                work_o.red   = b;
                work_o.green = green_q;
                work_o.blue  = blue_q;
                // end of row, end of image
                if ({1'b0, col_q} + 1'b1 >= {1'b0, img_w_q}) begin
                  col_d = '0;
                  if ({1'b0, row_q} + 1'b1 >= {1'b0, img_h_q}) begin
                    work_o.final_pixel = 1'b1;
                    phase              = PhDone;
                  end else begin
                    row_d = row_q + 1'b1;
                    pad_d = row_pad_q;
                  end
                end else begin
                  col_d = col_q + 1'b1;
                end
              end
            endcase
          end
        end
        default: ;
      endcase
    end

    phase_d   = phase;
    hdr_off_d = off;
    sig_ok_d  = sig;
    width_d   = ww;
    height_d  = hw;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      hdr_off_q <= '0;
      sig_ok_q  <= 1'b1;
      width_q   <= '0;
      height_q  <= '0;
      img_w_q   <= '0;
      img_h_q   <= '0;
      col_q     <= '0;
      row_q     <= '0;
      bip_q     <= '0;
      pad_q     <= '0;
      row_pad_q <= '0;
    end else begin
      phase_q   <= phase_d;
      hdr_off_q <= hdr_off_d;
      sig_ok_q  <= sig_ok_d;
      width_q   <= width_d;
      height_q  <= height_d;
      img_w_q   <= img_w_d;
      img_h_q   <= img_h_d;
      col_q     <= col_d;
      row_q     <= row_d;
      bip_q     <= bip_d;
      pad_q     <= pad_d;
      row_pad_q <= row_pad_d;
    end
  end

  // held color bytes
  always_ff @(posedge clk_i) begin
    blue_q  <= blue_d;
    green_q <= green_d;
  end

endmodule

>>> rtl/core/bmp24_queue.sv
module bmp24_queue import bmp24_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  work_t   push_data_i,
  input  logic    pop_i,
  output work_t   pop_data_o,
  output q_stat_t stat_o
);

  work_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]   cnt_q, cnt_d;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    if (!push_i && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  assign pop_data_o   = mem_q[rd_ptr_q];
  assign stat_o.valid = (cnt_q != '0);
  assign stat_o.full  = (cnt_q == (QPtrW + 1)'(QDepth));

endmodule

>>> rtl/core/bmp24_back.sv
module bmp24_back import bmp24_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      color_key_i,
  input  q_stat_t   q_stat_i,
  input  work_t     work_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q, out_data_d;
  logic      dark;

  // take the next entry when the output register is free or drains now
  assign pop_o = q_stat_i.valid && (!out_valid_q || !out_stall_i);

  // pixel formatting with optional color key
  always_comb begin
    dark        = work_i.blue < KeyLimit && work_i.green < KeyLimit &&
                  work_i.red < KeyLimit;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (pop_o) begin
      out_valid_d             = 1'b1;
      out_data_d.header_error = work_i.header_error;
      out_data_d.final_pixel  = work_i.final_pixel;
      if (work_i.header_error) begin
        out_data_d.red   = '0;
        out_data_d.green = '0;
        out_data_d.blue  = '0;
        out_data_d.alpha = '0;
      end else if (color_key_i) begin
        out_data_d.red   = dark ? 8'd0 : Opaque;
        out_data_d.green = dark ? 8'd0 : Opaque;
        out_data_d.blue  = dark ? 8'd0 : Opaque;
        out_data_d.alpha = dark ? 8'd0 : Opaque;
      end else begin
        out_data_d.red   = work_i.red;
        out_data_d.green = work_i.green;
        out_data_d.blue  = work_i.blue;
        out_data_d.alpha = Opaque;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> rtl/core/bmp24_to_rgba_stream_decoder_core.sv
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_stall_o   in_item_t  (data_byte, file_start)
// out       output     out_valid_o / out_stall_i out_item_t (rgba, header_error, final_pixel)
// cfg       input      cfg_we_i                  cfg_wdata_i (color key enable)
//
// one byte per cycle while out_stall_i is low; a pixel is queued, then registered out.
// the front parser decides per byte, a two-entry queue feeds the output stage.
// in_stall_o rises only while the queue holds two entries.
// reset clears all control state, phase goes idle, color key off.
// an output stall fills the queue before the input side stalls.
`include "bmp24_to_rgba_stream_decoder_core_assert.svh"

module bmp24_to_rgba_stream_decoder_core import bmp24_pkg::*; #(
  parameter int MAX_DIM = MaxDimDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i
);

  logic    color_key_q;
  logic    in_acc;
  logic    push;
  logic    pop;
  work_t   push_work;
  work_t   pop_work;
  q_stat_t q_stat;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_key_q <= 1'b0;
    end else if (cfg_we_i) begin
      color_key_q <= cfg_wdata_i;
    end
  end

  assign in_stall_o = q_stat.full;
  assign in_acc     = in_valid_i && !in_stall_o;

  bmp24_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .acc_i (in_acc),
    .item_i(in_data_i),
    .push_o(push),
    .work_o(push_work)
  );

  bmp24_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_work),
    .pop_i      (pop),
    .pop_data_o (pop_work),
    .stat_o     (q_stat)
  );

  bmp24_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .color_key_i(color_key_q),
    .q_stat_i   (q_stat),
    .work_i     (pop_work),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // a full queue must hold off the input side
  `BMP_ASSERT_ALWAYS(a_full_stalls, q_stat.full |-> in_stall_o, "queue full without stall")

  // header errors carry a zero pixel
  `BMP_ASSERT(a_err_zero, (out_valid_o && out_data_o.header_error) |-> (out_data_o.red == 8'd0 && out_data_o.alpha == 8'd0 && !out_data_o.final_pixel), "header error with pixel data")

  // a pixel is either keyed out or opaque
  `BMP_ASSERT(a_alpha_code, (out_valid_o && !out_data_o.header_error) |-> (out_data_o.alpha == 8'd0 || out_data_o.alpha == 8'hff), "bad alpha value")

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench import bmp24_pkg::*; ();

  localparam int HdrBytes   = 54;
  localparam int Whole      = 1 << 30;
  localparam int ItemTarget = 1350;
  localparam int LongHold   = 150;
  localparam int IdleLimit  = 2000;
  localparam int DrainWait  = 8;
  localparam int NumCases   = 17;

  localparam out_item_t HdrErrItem = '{red: 8'h00, green: 8'h00, blue: 8'h00, alpha: 8'h00,
                                       header_error: 1'b1, final_pixel: 1'b0};

  // one directed file
  typedef struct {
    bit          key;
    logic [7:0]  sig0;
    logic [7:0]  sig1;
    logic [31:0] wd;
    logic [31:0] ht;
    int          hdr_len;
    int          pix_len;
    int          tail;
    int          lead;
    bit          typed;
  } file_case_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic      cfg_we_i    = 1'b0;
  logic      cfg_wdata_i = 1'b0;

  // decoder state as the bytes imply it
  bit          key_on;
  logic [5:0]  hdr_pos;
  bit          sig_good;
  logic [31:0] w_word;
  logic [31:0] h_word;
  logic [12:0] img_w;
  logic [12:0] img_h;
  logic [12:0] col_pos;
  logic [12:0] row_pos;
  logic [1:0]  chan_pos;
  logic [7:0]  blue_hold;
  logic [7:0]  green_hold;
  logic [1:0]  pad_cnt;
  phase_e      stage;

  out_item_t expected_pixels[$];
  bit        typed_on;
  int        errors;
  int        data_bytes;
  int        idle_cycles;
  bit        gaps_on;
  bit        stall_rand;
  int        hold_requests;
  int        holds_done;

  // directed files: extremes, every special case, header faults typed in
  file_case_t dir_cases [NumCases] = '{
    // stray bytes while idle, single pixel image, bytes after the image
    '{0, SigB, SigM, 32'd1, 32'd1, HdrBytes, Whole, 3, 4, 0},
    '{0, SigB, SigM, 32'd3, 32'd2, HdrBytes, Whole, 0, 0, 0},
    '{1, SigB, SigM, 32'd2, 32'd2, HdrBytes, Whole, 0, 0, 0},
    '{1, SigB, SigM, 32'd5, 32'd1, HdrBytes, Whole, 2, 0, 0},
    // header faults, later bytes ignored until the next file start
    '{0, 8'h41, SigM, 32'd1, 32'd1, HdrBytes, 0, 5, 0, 1},
    '{1, SigB, 8'h4e, 32'd2, 32'd1, HdrBytes, 0, 5, 0, 1},
    '{0, SigB, SigM, 32'd0, 32'd3, HdrBytes, 0, 3, 0, 1},
    '{0, SigB, SigM, 32'd3, 32'd0, HdrBytes, 0, 3, 0, 1},
    '{0, SigB, SigM, 32'd4097, 32'd1, HdrBytes, 0, 2, 0, 1},
    '{0, SigB, SigM, 32'd2, 32'hffff_ffff, HdrBytes, 0, 2, 0, 1},
    '{0, SigB, SigM, 32'h0001_0002, 32'd1, HdrBytes, 0, 2, 0, 1},
    '{0, 8'hff, 8'h00, 32'd1, 32'd1, HdrBytes, 0, 1, 0, 1},
    // largest dimensions accepted, file cut short and restarted
    '{0, SigB, SigM, 32'd4096, 32'd1, HdrBytes, 12, 0, 0, 0},
    '{1, SigB, SigM, 32'd1, 32'd4096, HdrBytes, 9, 0, 0, 0},
    // header cut short, then two whole files
    '{0, SigB, SigM, 32'd2, 32'd2, 30, 0, 0, 0, 0},
    '{0, SigB, SigM, 32'd4, 32'd3, HdrBytes, Whole, 0, 0, 0},
    '{1, SigB, SigM, 32'd1, 32'd3, HdrBytes, Whole, 1, 0, 0}
  };

  bmp24_to_rgba_stream_decoder_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic void reset_decoder_state();
    key_on     = 1'b0;
    hdr_pos    = '0;
    sig_good   = 1'b1;
    w_word     = '0;
    h_word     = '0;
    img_w      = '0;
    img_h      = '0;
    col_pos    = '0;
    row_pos    = '0;
    chan_pos   = '0;
    blue_hold  = '0;
    green_hold = '0;
    pad_cnt    = '0;
    stage      = PhIdle;
  endfunction

  // advances the decoder state by one byte, returns 1 when a pixel or header error is due
  function automatic bit decode_byte(input in_item_t it, output out_item_t px);
    logic [7:0] b;
    int         k;
    b  = it.data_byte;
    px = '0;
    if (it.file_start) begin
      hdr_pos    = '0;
      img_w      = '0;
      img_h      = '0;
      col_pos    = '0;
      row_pos    = '0;
      chan_pos   = '0;
      blue_hold  = '0;
      green_hold = '0;
      pad_cnt    = '0;
      sig_good   = 1'b1;
      w_word     = '0;
      h_word     = '0;
      stage      = PhHeader;
    end
    case (stage)
      PhHeader: begin
        k = int'(hdr_pos);
        if (k == 0 && b != SigB) sig_good = 1'b0;
        if (k == 1 && b != SigM) sig_good = 1'b0;
        if (k >= int'(WidthOff) && k < int'(WidthOff) + 4) begin
          w_word[8*(k-int'(WidthOff)) +: 8] = b;
        end
        if (k >= int'(HeightOff) && k < int'(HeightOff) + 4) begin
          h_word[8*(k-int'(HeightOff)) +: 8] = b;
        end
        if (k < int'(LastHdr)) begin
          hdr_pos = hdr_pos + 6'd1;
          return 1'b0;
        end
        if (!sig_good || w_word == 0 || w_word > MaxDimDefault ||
            h_word == 0 || h_word > MaxDimDefault) begin
          stage = PhDone;
          px.header_error = 1'b1;
          return 1'b1;
        end
        img_w    = w_word[12:0];
        img_h    = h_word[12:0];
        col_pos  = '0;
        row_pos  = '0;
        chan_pos = '0;
        pad_cnt  = '0;
        stage    = PhPixels;
        return 1'b0;
      end
      PhPixels: begin
        if (pad_cnt != 0) begin
          pad_cnt = pad_cnt - 2'd1;
          return 1'b0;
        end
        if (chan_pos == 0) begin
          blue_hold = b;
          chan_pos  = 2'd1;
          return 1'b0;
        end
        if (chan_pos == 1) begin
          green_hold = b;
          chan_pos   = 2'd2;
          return 1'b0;
        end
        chan_pos = 2'd0;
        if (key_on) begin
          if (blue_hold < KeyLimit && green_hold < KeyLimit && b < KeyLimit) begin
            px.red   = 8'h00;
            px.green = 8'h00;
            px.blue  = 8'h00;
            px.alpha = 8'h00;
          end else begin
            px.red   = Opaque;
            px.green = Opaque;
            px.blue  = Opaque;
            px.alpha = Opaque;
          end
        end else begin
          px.red   = b;
          px.green = green_hold;
          px.blue  = blue_hold;
          px.alpha = Opaque;
        end
        // end of row: wrap, then either finish or skip the row padding
        if (int'(col_pos) + 1 >= int'(img_w)) begin
          col_pos = '0;
          if (int'(row_pos) + 1 >= int'(img_h)) begin
            px.final_pixel = 1'b1;
            stage = PhDone;
          end else begin
            row_pos = row_pos + 13'd1;
            pad_cnt = 2'((4 - (3 * int'(img_w)) % 4) % 4);
          end
        end else begin
          col_pos = col_pos + 13'd1;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // transfer monitor, scoreboard and watchdog
  always @(posedge clk_i) begin : monitor
    out_item_t px;
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          $error("pixel transfer with nothing expected");
          errors++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("red", want.red, out_data_o.red);
          check_field("green", want.green, out_data_o.green);
          check_field("blue", want.blue, out_data_o.blue);
          check_field("alpha", want.alpha, out_data_o.alpha);
          check_field("header_error", want.header_error, out_data_o.header_error);
          check_field("final_pixel", want.final_pixel, out_data_o.final_pixel);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        if (decode_byte(in_data_i, px)) begin
          expected_pixels.push_back(typed_on ? HdrErrItem : px);
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // receiver: short random stalls, rare long ones, and requested hold-offs
  initial begin : out_side
    int n;
    @(posedge clk_i);
    forever begin
      if (holds_done != hold_requests) begin
        holds_done = hold_requests;
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
      end else if (stall_rand && $urandom_range(0, 2) == 0) begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  task automatic sender_gap();
    int r;
    int n;
    if (!gaps_on) return;
    r = $urandom_range(0, 99);
    if (r < 70) n = 0;
    else if (r < 95) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 30);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // offer one byte and hold it until the transfer
  task automatic push_byte(input logic [7:0] b, input bit st);
    in_data_i  <= '{data_byte: b, file_start: st};
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    data_bytes++;
    sender_gap();
  endtask

  // wait until every expected pixel is out and the pipeline is empty
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic set_color_key(input bit v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    key_on = v;
  endtask

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'h04;
      2: return 8'h05;
      3: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // pixel area: bgr triples with row padding, stops after limit bytes
  task automatic send_pixels(input logic [31:0] wd, input logic [31:0] ht, input int limit);
    longint r;
    longint c;
    int     k;
    int     pad;
    int     sent;
    bit     dark;
    sent = 0;
    pad  = (4 - (3 * int'(wd[1:0])) % 4) % 4;
    for (r = 0; r < ht; r++) begin
      for (c = 0; c < wd; c++) begin
        dark = ($urandom_range(0, 3) == 0);
        for (k = 0; k < 3; k++) begin
          if (sent >= limit) return;
          push_byte(dark ? 8'($urandom_range(0, 5)) : pick_channel(), 1'b0);
          sent++;
        end
      end
      if (r + 1 < ht) begin
        for (k = 0; k < pad; k++) begin
          if (sent >= limit) return;
          push_byte(8'($urandom), 1'b0);
          sent++;
        end
      end
    end
  endtask

  task automatic send_file(input logic [7:0] s0, input logic [7:0] s1,
                           input logic [31:0] wd, input logic [31:0] ht,
                           input int hdr_len, input int pix_len, input int tail,
                           input int lead);
    int         k;
    logic [7:0] b;
    for (k = 0; k < lead; k++) push_byte(8'($urandom), 1'b0);
    for (k = 0; k < hdr_len; k++) begin
      if (k == 0) b = s0;
      else if (k == 1) b = s1;
      else if (k >= int'(WidthOff) && k < int'(WidthOff) + 4) b = wd[8*(k-int'(WidthOff)) +: 8];
      else if (k >= int'(HeightOff) && k < int'(HeightOff) + 4) b = ht[8*(k-int'(HeightOff)) +: 8];
      else b = 8'($urandom);
      push_byte(b, k == 0);
    end
    send_pixels(wd, ht, pix_len);
    for (k = 0; k < tail; k++) push_byte(8'($urandom), 1'b0);
  endtask

  initial begin : stimulus
    int          i;
    int          k;
    int          n;
    int          kind;
    int          files;
    logic [7:0]  s0;
    logic [7:0]  s1;
    logic [31:0] wd;
    logic [31:0] ht;
    reset_decoder_state();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed files, one at a time from an idle block
    for (i = 0; i < NumCases; i++) begin
      settle();
      set_color_key(dir_cases[i].key);
      typed_on   = dir_cases[i].typed;
      gaps_on    = (i % 3 != 0);
      stall_rand = (i % 4 != 1);
      send_file(dir_cases[i].sig0, dir_cases[i].sig1, dir_cases[i].wd, dir_cases[i].ht,
                dir_cases[i].hdr_len, dir_cases[i].pix_len, dir_cases[i].tail,
                dir_cases[i].lead);
    end
    settle();
    typed_on = 1'b0;

    // random files until the byte budget is used: mostly well formed, some broken or cut
    files = 0;
    while (data_bytes < ItemTarget) begin
      if ($urandom_range(0, 3) == 0) begin
        settle();
        set_color_key($urandom_range(0, 1));
      end
      n          = $urandom_range(0, 9);
      gaps_on    = (n > 1);
      stall_rand = (n != 0 && n != 5);
      kind       = $urandom_range(0, 19);
      if (files == 0 || files == 4) begin
        // long receiver hold-off while the sender keeps offering
        gaps_on = 1'b0;
        hold_requests++;
        send_file(SigB, SigM, 32'd6, 32'd4, HdrBytes, Whole, 0, 0);
      end else if (kind < 14) begin
        wd = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 7);
        ht = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
        send_file(SigB, SigM, wd, ht, HdrBytes, Whole, $urandom_range(0, 3), 0);
      end else if (kind == 14) begin
        wd = $urandom_range(1, 7);
        ht = $urandom_range(1, 4);
        send_file(SigB, SigM, wd, ht, HdrBytes, $urandom_range(0, 20), 0, 0);
      end else if (kind < 17) begin
        s0 = SigB;
        s1 = SigM;
        wd = $urandom_range(1, 7);
        ht = $urandom_range(1, 4);
        case ($urandom_range(0, 5))
          0: begin
            s0 = 8'($urandom);
            if (s0 == SigB) s0 = s0 ^ 8'h01;
          end
          1: begin
            s1 = 8'($urandom);
            if (s1 == SigM) s1 = s1 ^ 8'h80;
          end
          2: wd = '0;
          3: ht = '0;
          4: wd = MaxDimDefault + 1 + $urandom_range(0, 1000000);
          default: ht = $urandom | 32'h8000_0000;
        endcase
        send_file(s0, s1, wd, ht, HdrBytes, 0, $urandom_range(0, 4), 0);
      end else if (kind == 17) begin
        send_file(SigB, SigM, 32'd2, 32'd2, $urandom_range(1, 53), 0, 0, 0);
      end else if (kind == 18) begin
        // stray bytes, now and then a file start in the middle of them
        n = $urandom_range(5, 12);
        for (k = 0; k < n; k++) push_byte(8'($urandom), $urandom_range(0, 7) == 0);
      end else begin
        send_file(8'($urandom), 8'($urandom), $urandom, $urandom, HdrBytes, 6, 2, 0);
      end
      files++;
    end

    settle();
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/bmp24_pkg.sv
rtl/core/bmp24_front.sv
rtl/core/bmp24_queue.sv
rtl/core/bmp24_back.sv
rtl/core/bmp24_to_rgba_stream_decoder_core.sv
tb/sv/testbench.sv
